@@ design/rid_pkg.sv @@
`default_nettype none

package rid_pkg;

	// Table geometry. The ID field is fixed at ten bits, so the table holds 2**10 IDs.
	localparam int ID_W       = 10;
	localparam int ID_COUNT   = 1 << ID_W;
	localparam int DATA_WIDTH = 32;

	// Used marks are held as rows of 32 flags, one row per memory word.
	localparam int LANE_W    = 5;
	localparam int ROW_BITS  = 1 << LANE_W;
	localparam int ROW_W     = ID_W - LANE_W;
	localparam int ROW_COUNT = ID_COUNT / ROW_BITS;
	localparam int VISIT_W   = $clog2(ROW_COUNT + 1);

	localparam logic [ID_W-1:0] FIRST_ID = ID_W'(1);

	// Operation codes.
	localparam logic [2:0] OP_AUTO    = 3'd0;
	localparam logic [2:0] OP_INSERT  = 3'd1;
	localparam logic [2:0] OP_REPLACE = 3'd2;
	localparam logic [2:0] OP_LOOKUP  = 3'd3;
	localparam logic [2:0] OP_REMOVE  = 3'd4;

	// Status codes.
	localparam logic [2:0] STAT_OK         = 3'd0;
	localparam logic [2:0] STAT_IN_USE     = 3'd1;
	localparam logic [2:0] STAT_NOT_FOUND  = 3'd2;
	localparam logic [2:0] STAT_INVALID    = 3'd3;
	localparam logic [2:0] STAT_OUT_OF_IDS = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EVAL
	} state_t;

	typedef struct packed {
		logic [2:0]      operation;
		logic [ID_W-1:0] req_id;
		logic [31:0]     data_in;
	} req_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [ID_W-1:0] result_id;
		logic [31:0]     data_out;
		logic            found;
	} rsp_t;

	typedef struct packed {
		logic                en;
		logic [ROW_W-1:0]    row;
		logic [ROW_BITS-1:0] bits;
	} mark_wr_t;

	typedef struct packed {
		logic                  en;
		logic [ID_W-1:0]       addr;
		logic [DATA_WIDTH-1:0] data;
	} data_wr_t;

	// Index of the lowest set bit; zero when none is set.
	function automatic logic [LANE_W-1:0] first_set(input logic [ROW_BITS-1:0] v);
		logic [LANE_W-1:0] idx;
		idx = '0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = LANE_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

@@ design/rolling_id_allocator_table_top.sv @@
// A result is loaded once its item has passed through S_READ and S_EVAL; it waits in S_EVAL
// while the output is stalled. Requests stall until S_IDLE; an auto insert reads a further row
// of 32 used marks for each full row that it scans (at most 33 row reads).
// The used-mark memory read, one row a step, paces the auto insert scan.
// Reset clears the row valid flags, so the table reads empty at once; the pointer is 1.
`default_nettype none

module rolling_id_allocator_table_top (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  rid_pkg::req_t  req,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output rid_pkg::rsp_t  rsp
);
	import rid_pkg::*;

	state_t               state_q, state_d;
	req_t                 req_q, req_d;
	logic [ROW_W-1:0]     row_q, row_d;
	logic [VISIT_W-1:0]   visit_q, visit_d;
	logic [ID_W-1:0]      next_q, next_d;
	rsp_t                 rsp_q, rsp_d;
	logic                 rsp_valid_q;
	logic                 load_rsp;
	logic                 rd_en;
	logic                 accept;
	logic                 out_free;
	logic [ROW_BITS-1:0]  mark_rd;
	logic [DATA_WIDTH-1:0] data_rd;
	mark_wr_t             mark_wr;
	data_wr_t             data_wr;

	logic [LANE_W-1:0]    lane_sel;
	logic                 entry_used;
	logic [ROW_BITS-1:0]  scan_mask;
	logic [ROW_BITS-1:0]  free_bits;
	logic                 any_free;
	logic [LANE_W-1:0]    pick;
	logic [ID_W-1:0]      hit_id;
	logic [ID_W-1:0]      hit_next;
	logic                 req_id_ok;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	rid_mark_mem u_marks (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_row  (row_q),
		.rd_bits (mark_rd),
		.wr      (mark_wr)
	);

	rid_data_ram u_data (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (req_q.req_id),
		.rd_data (data_rd),
		.wr      (data_wr)
	);

	// Lookup of the named entry in the row just read.
	assign lane_sel   = req_q.req_id[LANE_W-1:0];
	assign entry_used = mark_rd[lane_sel];
	assign req_id_ok  = (req_q.req_id != '0);

	// Auto insert scan: the first visit of the start row looks at and after the pointer,
	// the final revisit looks before it; ID 0 is never a candidate.
	always_comb begin
		if (visit_q == '0) begin
			scan_mask = {ROW_BITS{1'b1}} << next_q[LANE_W-1:0];
		end else if (visit_q == VISIT_W'(ROW_COUNT)) begin
			scan_mask = ~({ROW_BITS{1'b1}} << next_q[LANE_W-1:0]);
		end else begin
			scan_mask = {ROW_BITS{1'b1}};
		end
		if (row_q == '0) begin
			scan_mask[0] = 1'b0;
		end
	end

	assign free_bits = ~mark_rd & scan_mask;
	assign any_free  = |free_bits;
	assign pick      = first_set(free_bits);
	assign hit_id    = {row_q, pick};
	assign hit_next  = (hit_id == {ID_W{1'b1}}) ? FIRST_ID : ID_W'(hit_id + 1'b1);

	// Sequencer: next state, memory accesses and result.
	always_comb begin
		state_d  = state_q;
		req_d    = req_q;
		row_d    = row_q;
		visit_d  = visit_q;
		next_d   = next_q;
		rd_en    = 1'b0;
		load_rsp = 1'b0;
		rsp_d    = '0;
		mark_wr  = '0;
		data_wr  = '0;
		mark_wr.row  = row_q;
		data_wr.addr = req_q.req_id;
		data_wr.data = req_q.data_in[DATA_WIDTH-1:0];

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_d   = req;
					visit_d = '0;
					if (req.operation == OP_AUTO) begin
						row_d = next_q[ID_W-1:LANE_W];
					end else begin
						row_d = req.req_id[ID_W-1:LANE_W];
					end
					state_d = S_READ;
				end
			end

			S_READ: begin
				rd_en   = 1'b1;
				state_d = S_EVAL;
			end

			S_EVAL: begin
				if (req_q.operation == OP_AUTO && !any_free &&
				    visit_q != VISIT_W'(ROW_COUNT)) begin
					// Move the scan on to the next row, wrapping.
					row_d   = ROW_W'(row_q + 1'b1);
					visit_d = VISIT_W'(visit_q + 1'b1);
					state_d = S_READ;
				end else if (out_free) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
					case (req_q.operation)
						OP_AUTO: begin
							if (any_free) begin
								mark_wr.en   = 1'b1;
								mark_wr.bits = mark_rd | (ROW_BITS'(1) << pick);
								data_wr.en   = 1'b1;
								data_wr.addr = hit_id;
								next_d       = hit_next;
								rsp_d.status    = STAT_OK;
								rsp_d.result_id = hit_id;
							end else begin
								rsp_d.status = STAT_OUT_OF_IDS;
							end
						end
						OP_INSERT: begin
							if (!req_id_ok) begin
								rsp_d.status = STAT_INVALID;
							end else if (entry_used) begin
								rsp_d.status = STAT_IN_USE;
							end else begin
								mark_wr.en   = 1'b1;
								mark_wr.bits = mark_rd | (ROW_BITS'(1) << lane_sel);
								data_wr.en   = 1'b1;
								rsp_d.status    = STAT_OK;
								rsp_d.result_id = req_q.req_id;
							end
						end
						OP_REPLACE: begin
							if (!req_id_ok) begin
								rsp_d.status = STAT_INVALID;
							end else begin
								mark_wr.en   = 1'b1;
								mark_wr.bits = mark_rd | (ROW_BITS'(1) << lane_sel);
								data_wr.en   = 1'b1;
								rsp_d.status    = STAT_OK;
								rsp_d.result_id = req_q.req_id;
							end
						end
						OP_LOOKUP: begin
							if (!req_id_ok) begin
								rsp_d.status = STAT_INVALID;
							end else if (entry_used) begin
								rsp_d.status    = STAT_OK;
								rsp_d.result_id = req_q.req_id;
								rsp_d.data_out  = 32'(data_rd);
								rsp_d.found     = 1'b1;
							end else begin
								rsp_d.status = STAT_NOT_FOUND;
							end
						end
						OP_REMOVE: begin
							if (!req_id_ok) begin
								rsp_d.status = STAT_INVALID;
							end else if (entry_used) begin
								mark_wr.en   = 1'b1;
								mark_wr.bits = mark_rd & ~(ROW_BITS'(1) << lane_sel);
								rsp_d.status    = STAT_OK;
								rsp_d.result_id = req_q.req_id;
								rsp_d.found     = 1'b1;
							end else begin
								rsp_d.status = STAT_NOT_FOUND;
							end
						end
						default: begin
							rsp_d.status = STAT_INVALID;
						end
					endcase
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			next_q      <= FIRST_ID;
			visit_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			next_q  <= next_d;
			visit_q <= visit_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		req_q <= req_d;
		row_q <= row_d;
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	// An accepted item always goes on to a memory read.
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_READ)
		else $error("accepted item did not start a read");

	// Marks are written only while evaluating, never alongside a read.
	a_write_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		mark_wr.en |-> (state_q == S_EVAL && !rd_en))
		else $error("used-mark write outside evaluation");

	// A result is loaded only when the output register is free.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_rsp |-> out_free)
		else $error("result overwrote a waiting result");

	// A successful result always names a valid ID.
	a_ok_id: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == STAT_OK) |-> rsp_q.result_id != '0)
		else $error("successful result with ID 0");

	// The rolling pointer never rests on ID 0 and the scan never overruns.
	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(next_q != '0) && (visit_q <= VISIT_W'(ROW_COUNT)))
		else $error("pointer or scan count out of range");
`endif

endmodule

`default_nettype wire

@@ design/rid_mark_mem.sv @@
`default_nettype none

module rid_mark_mem (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          rd_en,
	input  wire  [rid_pkg::ROW_W-1:0]    rd_row,
	output logic [rid_pkg::ROW_BITS-1:0] rd_bits,
	input  rid_pkg::mark_wr_t            wr
);
	import rid_pkg::*;

	logic [ROW_BITS-1:0]  mem [ROW_COUNT];
	logic [ROW_BITS-1:0]  rd_data_q;
	logic                 rd_row_valid_q;
	logic [ROW_COUNT-1:0] row_valid_q;

	// Row valid flags: a row never written reads as all free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr.en) begin
			row_valid_q[wr.row] <= 1'b1;
		end
	end

	// Synchronous write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.row] <= wr.bits;
		end
	end

	// Registered read port, with the row valid flag sampled alongside.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q      <= mem[rd_row];
			rd_row_valid_q <= row_valid_q[rd_row];
		end
	end

	assign rd_bits = rd_row_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

@@ design/rid_data_ram.sv @@
`default_nettype none

module rid_data_ram (
	input  wire                            clk,
	input  wire                            rd_en,
	input  wire  [rid_pkg::ID_W-1:0]       rd_addr,
	output logic [rid_pkg::DATA_WIDTH-1:0] rd_data,
	input  rid_pkg::data_wr_t              wr
);
	import rid_pkg::*;

	logic [DATA_WIDTH-1:0] mem [ID_COUNT];

	// Single write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import rid_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	// Items waiting to be driven and the responses the table should give.
	req_t  pending_reqs[$];
	rsp_t  awaited_rsps[$];

	// Our own copy of the ID table.
	bit              model_used [0:ID_COUNT-1];
	logic [31:0]     model_word [0:ID_COUNT-1];
	logic [ID_W-1:0] model_next_id;

	int    total_items  = 0;
	int    items_sent   = 0;
	int    mismatches   = 0;
	int    stuck_cycles = 0;
	int    send_idle_pct;
	int    recv_idle_pct;

	rolling_id_allocator_table_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Idling follows the progress of the run: receiver-heavy, then sender-heavy, then none.
	always_comb begin
		if (items_sent < total_items / 3) begin
			send_idle_pct = 38;
			recv_idle_pct = 76;
		end else if (items_sent < (2 * total_items) / 3) begin
			send_idle_pct = 76;
			recv_idle_pct = 38;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	end

	// Works out the response to one accepted item and updates the table copy.
	task automatic predict_table_rsp(input req_t r);
		rsp_t            want;
		logic [ID_W-1:0] cand;
		logic [ID_W-1:0] this_id;
		bit              placed;
		want   = '0;
		placed = 1'b0;
		case (r.operation)
			OP_AUTO: begin
				cand = model_next_id;
				for (int tries = 0; tries < ID_COUNT - 1 && !placed; tries++) begin
					this_id = cand;
					cand = (cand == ID_W'(ID_COUNT - 1)) ? FIRST_ID : cand + 1'b1;
					if (!model_used[this_id]) begin
						model_used[this_id] = 1'b1;
						model_word[this_id] = r.data_in;
						want.status    = STAT_OK;
						want.result_id = this_id;
						placed = 1'b1;
					end
				end
				// A full table walks the pointer all the way round to where it began.
				model_next_id = cand;
				if (!placed) begin
					want.status = STAT_OUT_OF_IDS;
				end
			end
			OP_INSERT, OP_REPLACE, OP_LOOKUP, OP_REMOVE: begin
				if (r.req_id == '0) begin
					want.status = STAT_INVALID;
				end else if (r.operation == OP_INSERT && model_used[r.req_id]) begin
					want.status = STAT_IN_USE;
				end else if (r.operation == OP_INSERT || r.operation == OP_REPLACE) begin
					model_used[r.req_id] = 1'b1;
					model_word[r.req_id] = r.data_in;
					want.status    = STAT_OK;
					want.result_id = r.req_id;
				end else if (!model_used[r.req_id]) begin
					want.status = STAT_NOT_FOUND;
				end else begin
					want.status    = STAT_OK;
					want.result_id = r.req_id;
					want.found     = 1'b1;
					if (r.operation == OP_LOOKUP) begin
						want.data_out = model_word[r.req_id];
					end else begin
						model_used[r.req_id] = 1'b0;
					end
				end
			end
			default: begin
				want.status = STAT_INVALID;
			end
		endcase
		awaited_rsps.push_back(want);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
		mismatches++;
	endtask

	task automatic queue_req(input logic [2:0] op, input logic [ID_W-1:0] id,
			input logic [31:0] data);
		req_t r;
		r.operation = op;
		r.req_id    = id;
		r.data_in   = data;
		pending_reqs.push_back(r);
	endtask

	// IDs cluster in the first rows so that hits are common, with the odd stray and invalid one.
	function automatic logic [ID_W-1:0] pick_id();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			return '0;
		end else if (roll < 16) begin
			return ID_W'($urandom_range(1, ID_COUNT - 1));
		end else if (roll < 20) begin
			return ID_W'(ID_COUNT - 1);
		end
		return ID_W'($urandom_range(1, 48));
	endfunction

	function automatic logic [2:0] pick_op();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 20) begin
			return OP_AUTO;
		end else if (roll < 35) begin
			return OP_INSERT;
		end else if (roll < 50) begin
			return OP_REPLACE;
		end else if (roll < 75) begin
			return OP_LOOKUP;
		end else if (roll < 95) begin
			return OP_REMOVE;
		end
		return 3'($urandom_range(5, 7));
	endfunction

	// Driver: presents the next item and holds it until the table takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				predict_table_rsp(req);
				items_sent <= items_sent + 1;
			end
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req       <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stalls at random and checks each response against the oldest one awaited.
	always @(posedge clk or negedge arst_n) begin : rsp_check
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsps.size() == 0) begin
					report_mismatch("response with nothing awaited", '0, 32'(rsp.status));
				end else begin
					want = awaited_rsps.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(want.status), 32'(rsp.status));
					if (rsp.result_id !== want.result_id)
						report_mismatch("result_id", 32'(want.result_id), 32'(rsp.result_id));
					if (rsp.data_out !== want.data_out)
						report_mismatch("data_out", want.data_out, rsp.data_out);
					if (rsp.found !== want.found)
						report_mismatch("found", 32'(want.found), 32'(rsp.found));
				end
			end
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Watchdog: ends the run if no item moves on either side for too long.
	initial begin
		while (stuck_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Stimulus, reset and end of run.
	initial begin
		for (int i = 0; i < ID_COUNT; i++) begin
			model_used[i] = 1'b0;
			model_word[i] = '0;
		end
		model_next_id = FIRST_ID;

		// Directed: empty table, data extremes, pointer skipping, invalid IDs, unknown codes.
		queue_req(OP_LOOKUP, ID_W'(1), 32'h0);
		queue_req(OP_REMOVE, ID_W'(1), 32'h0);
		queue_req(OP_AUTO, ID_W'(0), 32'h0000_0000);
		queue_req(OP_AUTO, ID_W'(ID_COUNT - 1), 32'hFFFF_FFFF);
		queue_req(OP_LOOKUP, ID_W'(1), 32'h0);
		queue_req(OP_LOOKUP, ID_W'(2), 32'hFFFF_FFFF);
		queue_req(OP_INSERT, ID_W'(ID_COUNT - 1), 32'hA5A5_5A5A);
		queue_req(OP_LOOKUP, ID_W'(ID_COUNT - 1), 32'h0);
		queue_req(OP_INSERT, ID_W'(ID_COUNT - 1), 32'h1234_5678);
		queue_req(OP_INSERT, ID_W'(4), 32'h0BAD_F00D);
		queue_req(OP_AUTO, ID_W'(4), 32'h5555_AAAA);
		queue_req(OP_AUTO, ID_W'(0), 32'hAAAA_5555);
		queue_req(OP_REPLACE, ID_W'(3), 32'hDEAD_BEEF);
		queue_req(OP_REPLACE, ID_W'(600), 32'hC0FF_EE00);
		queue_req(OP_LOOKUP, ID_W'(600), 32'h0);
		queue_req(OP_INSERT, ID_W'(0), 32'hFFFF_FFFF);
		queue_req(OP_REPLACE, ID_W'(0), 32'hFFFF_FFFF);
		queue_req(OP_LOOKUP, ID_W'(0), 32'h0);
		queue_req(OP_REMOVE, ID_W'(0), 32'h0);
		queue_req(3'd5, ID_W'(ID_COUNT - 1), 32'hFFFF_FFFF);
		queue_req(3'd6, ID_W'(5), $urandom);
		queue_req(3'd7, ID_W'(0), $urandom);
		queue_req(OP_REMOVE, ID_W'(2), 32'h0);
		queue_req(OP_LOOKUP, ID_W'(2), 32'h0);
		queue_req(OP_REMOVE, ID_W'(2), 32'h0);

		// Mixed traffic on a crowded corner of the table.
		for (int i = 0; i < 150; i++) begin
			queue_req(pick_op(), pick_id(), $urandom);
		end

		// Fill the table through the pointer until it runs out of IDs, with lookups mixed in.
		for (int i = 0; i < 1030; i++) begin
			queue_req(OP_AUTO, ID_W'($urandom), $urandom);
			if (i % 10 == 9) begin
				queue_req(OP_LOOKUP, ID_W'($urandom_range(1, ID_COUNT - 1)), $urandom);
			end
		end

		// Punch holes in the full table and let auto insert hunt for them.
		for (int i = 0; i < 100; i++) begin
			queue_req(OP_REMOVE, ID_W'($urandom_range(1, ID_COUNT - 1)), $urandom);
			queue_req(OP_AUTO, ID_W'($urandom), $urandom);
		end

		for (int i = 0; i < 50; i++) begin
			queue_req(pick_op(), pick_id(), $urandom);
		end
		total_items = pending_reqs.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (items_sent < total_items || awaited_rsps.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (awaited_rsps.size() != 0) begin
			report_mismatch("responses left outstanding", '0, 32'(awaited_rsps.size()));
		end
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
